// ===== rtl/btt_pkg.sv =====
// Package for the byte table transliterator: sizes, action and kind codes,
// sequencer state type and the repeat-count helper.
// No dependencies.
package btt_pkg;

    localparam int MAX_REPEAT     = 16;
    localparam int MAX_STRING_LEN = 4;
    localparam int STRING_DEPTH   = 256;
    localparam int RESULT_LIMIT   = 64;

    localparam int REP_W  = $clog2(MAX_REPEAT + 1);
    localparam int LEN_W  = $clog2(MAX_STRING_LEN + 1);
    localparam int STR_AW = $clog2(STRING_DEPTH);
    localparam int ADDR_W = $clog2((STRING_DEPTH > 256) ? STRING_DEPTH : 256) + 1;
    localparam int CNT_W  = $clog2(RESULT_LIMIT);

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_TABLE  = 2'd1;
    localparam logic [1:0] KIND_STRING = 2'd2;

    localparam logic [2:0] ACT_COPY     = 3'd0;
    localparam logic [2:0] ACT_DELETE   = 3'd1;
    localparam logic [2:0] ACT_TRANS    = 3'd2;
    localparam logic [2:0] ACT_STRING   = 3'd3;
    localparam logic [2:0] ACT_REP_BYTE = 3'd4;
    localparam logic [2:0] ACT_REP_NEXT = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_WRAP,
        ST_FETCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [REP_W-1:0] rep;
        logic             clip;
    } rep_set_t;

    // Repeat count of at least one, clipped to MAX_REPEAT
    function automatic rep_set_t set_repeat(input logic [8:0] v);
        rep_set_t   f;
        logic [8:0] r;
        r = (v == 9'd0) ? 9'd1 : v;
        if (r > 9'(MAX_REPEAT)) begin
            f.rep  = REP_W'(MAX_REPEAT);
            f.clip = 1'b1;
        end else begin
            f.rep  = REP_W'(r);
            f.clip = 1'b0;
        end
        return f;
    endfunction

endpackage

// ===== rtl/byte_table_transliterator.sv =====
// Sequence: table writes finish while idle; a string store write passes wrap steps,
// then writes; a data byte passes lookup, then gives one copy/translate beat a cycle
// while m_ready is high; strings pass lookup and wrap, then fetch and emit per byte.
// Throughput: one input at a time; s_ready is high only between items.
// Reset: synchronous, active low; every action entry reads as copy, repeat state is
// cleared. The other tables hold nothing defined until written.
module byte_table_transliterator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [7:0] s_byte_in,
    input  logic [7:0] s_slot,
    input  logic [2:0] s_action,
    input  logic [7:0] s_value,
    input  logic [2:0] s_length,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last,
    output logic       m_clipped
);
    import btt_pkg::*;

    logic [2:0] act_mem [256];
    logic [7:0] map_mem [256];
    logic [2:0] len_mem [256];
    logic [7:0] str_mem [STRING_DEPTH];

    state_t state_reg, state_next;

    logic [255:0]      act_vld_reg, act_vld_next;
    logic [REP_W-1:0]  pend_rep_reg, pend_rep_next;
    logic              pend_clip_reg, pend_clip_next;
    logic              await_reg, await_next;

    logic [7:0]        byte_reg, byte_next;
    logic [7:0]        val_reg, val_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic              str_wr_reg, str_wr_next;
    logic              str_mode_reg, str_mode_next;
    logic [REP_W-1:0]  rep_cnt_reg, rep_cnt_next;
    logic [LEN_W-1:0]  str_left_reg, str_left_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic              clip_reg, clip_next;

    logic [2:0] act_rd_reg;
    logic       act_vld_rd_reg;
    logic [7:0] map_rd_reg;
    logic [2:0] len_rd_reg;
    logic [7:0] str_rd_reg;

    logic             accept;
    logic [2:0]       act_eff;
    logic [LEN_W-1:0] len_sat;
    logic [REP_W-1:0] reps;
    logic             addr_ge;
    logic             beat_last;
    logic             str_write;
    rep_set_t         rep_byte;
    rep_set_t         rep_count;

    assign accept  = s_valid && s_ready;
    assign act_eff = act_vld_rd_reg ? act_rd_reg : ACT_COPY;
    assign len_sat = ({29'd0, len_rd_reg} > 32'(MAX_STRING_LEN)) ? LEN_W'(MAX_STRING_LEN)
                                                                 : LEN_W'(len_rd_reg);
    assign reps    = (pend_rep_reg == '0) ? REP_W'(1) : pend_rep_reg;
    assign addr_ge = addr_reg >= ADDR_W'(STRING_DEPTH);

    // signed table entry: negative gives one pass, else entry + 1
    assign rep_count = set_repeat(map_rd_reg[7] ? 9'd1 : ({1'b0, map_rd_reg} + 9'd1));
    assign rep_byte  = set_repeat({1'b0, byte_reg});

    assign beat_last = ((rep_cnt_reg == REP_W'(1))
                        && (!str_mode_reg || (str_left_reg == LEN_W'(1))))
                       || (out_cnt_reg == CNT_W'(RESULT_LIMIT - 1));

    assign str_write = (state_reg == ST_WRAP) && !addr_ge && str_wr_reg;

    // table memories, read at the incoming byte while idle
    always_ff @(posedge aclk) begin
        if (accept && (s_kind == KIND_TABLE)) begin
            act_mem[s_slot] <= s_action;
            map_mem[s_slot] <= s_value;
            len_mem[s_slot] <= s_length;
        end
        if (state_reg == ST_IDLE) begin
            act_rd_reg     <= act_mem[s_byte_in];
            act_vld_rd_reg <= act_vld_reg[s_byte_in];
            map_rd_reg     <= map_mem[s_byte_in];
            len_rd_reg     <= len_mem[s_byte_in];
        end
    end

    always_ff @(posedge aclk) begin
        if (str_write) begin
            str_mem[addr_reg[STR_AW-1:0]] <= val_reg;
        end
        str_rd_reg <= str_mem[addr_reg[STR_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            act_vld_reg   <= '0;
            pend_rep_reg  <= '0;
            pend_clip_reg <= 1'b0;
            await_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            act_vld_reg   <= act_vld_next;
            pend_rep_reg  <= pend_rep_next;
            pend_clip_reg <= pend_clip_next;
            await_reg     <= await_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        val_reg      <= val_next;
        addr_reg     <= addr_next;
        start_reg    <= start_next;
        str_wr_reg   <= str_wr_next;
        str_mode_reg <= str_mode_next;
        rep_cnt_reg  <= rep_cnt_next;
        str_left_reg <= str_left_next;
        len_reg      <= len_next;
        out_cnt_reg  <= out_cnt_next;
        clip_reg     <= clip_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_kind == KIND_DATA)) begin
                    state_next = ST_LOOK;
                end else if (accept && (s_kind == KIND_STRING)) begin
                    state_next = ST_WRAP;
                end
            end
            ST_LOOK: begin
                if (await_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    unique case (act_eff)
                        ACT_COPY, ACT_TRANS: state_next = ST_EMIT;
                        ACT_STRING: state_next = (len_sat == '0) ? ST_IDLE : ST_WRAP;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRAP: begin
                if (!addr_ge) begin
                    state_next = str_wr_reg ? ST_IDLE : ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_EMIT;
            ST_EMIT: begin
                if (m_ready) begin
                    if (beat_last) begin
                        state_next = ST_IDLE;
                    end else if (str_mode_reg) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and repeat state
    always_comb begin
        act_vld_next   = act_vld_reg;
        pend_rep_next  = pend_rep_reg;
        pend_clip_next = pend_clip_reg;
        await_next     = await_reg;
        byte_next      = byte_reg;
        val_next       = val_reg;
        addr_next      = addr_reg;
        start_next     = start_reg;
        str_wr_next    = str_wr_reg;
        str_mode_next  = str_mode_reg;
        rep_cnt_next   = rep_cnt_reg;
        str_left_next  = str_left_reg;
        len_next       = len_reg;
        out_cnt_next   = out_cnt_reg;
        clip_next      = clip_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_TABLE) begin
                        act_vld_next[s_slot] = 1'b1;
                    end
                    byte_next   = s_byte_in;
                    val_next    = s_value;
                    addr_next   = ADDR_W'(s_slot);
                    str_wr_next = 1'b1;
                end
            end
            ST_LOOK: begin
                if (await_reg) begin
                    await_next     = 1'b0;
                    pend_rep_next  = rep_count.rep;
                    pend_clip_next = rep_count.clip;
                end else begin
                    pend_rep_next  = '0;
                    pend_clip_next = 1'b0;
                    clip_next      = pend_clip_reg;
                    rep_cnt_next   = reps;
                    out_cnt_next   = '0;
                    str_mode_next  = 1'b0;
                    str_wr_next    = 1'b0;
                    unique case (act_eff)
                        ACT_COPY:  val_next = byte_reg;
                        ACT_TRANS: val_next = map_rd_reg;
                        ACT_STRING: begin
                            str_mode_next = 1'b1;
                            len_next      = len_sat;
                            str_left_next = len_sat;
                            addr_next     = ADDR_W'(map_rd_reg);
                        end
                        ACT_REP_BYTE: begin
                            pend_rep_next  = rep_byte.rep;
                            pend_clip_next = rep_byte.clip;
                        end
                        ACT_REP_NEXT: await_next = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_WRAP: begin
                // one subtraction of the store depth a cycle
                if (addr_ge) begin
                    addr_next = addr_reg - ADDR_W'(STRING_DEPTH);
                end else begin
                    start_next = addr_reg;
                end
            end
            ST_FETCH: ;
            ST_EMIT: begin
                if (m_ready && !beat_last) begin
                    out_cnt_next = out_cnt_reg + CNT_W'(1);
                    if (!str_mode_reg) begin
                        rep_cnt_next = rep_cnt_reg - REP_W'(1);
                    end else if (str_left_reg == LEN_W'(1)) begin
                        rep_cnt_next  = rep_cnt_reg - REP_W'(1);
                        str_left_next = len_reg;
                        addr_next     = start_reg;
                    end else begin
                        str_left_next = str_left_reg - LEN_W'(1);
                        addr_next     = (addr_reg == ADDR_W'(STRING_DEPTH - 1))
                                        ? '0 : addr_reg + ADDR_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // outputs
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = (state_reg == ST_EMIT);
    assign m_out_byte = str_mode_reg ? str_rd_reg : val_reg;
    assign m_last     = beat_last;
    assign m_clipped  = clip_reg;

endmodule
